### sv/spe_pkg.sv
// shared types and packet build function for the servo packet encoder
`default_nettype none

package spe_pkg;

  localparam int unsigned IdW    = 7;
  localparam int unsigned CmdW   = 5;
  localparam int unsigned ValW   = 28;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned GrpW   = 7;
  localparam int unsigned NSlot  = 8;
  localparam int unsigned IdxW   = $clog2(NSlot);
  localparam int unsigned NGrp   = 4;

  localparam logic [ByteW-1:0] MarkBit = 8'h80;

  // packet image: byte slots in transmit order plus the slot of the checksum
  typedef struct packed {
    logic [NSlot-1:0][ByteW-1:0] bytes;
    logic [IdxW-1:0]             last_idx;
  } pkt_t;

  function automatic pkt_t build_pkt(input logic [IdW-1:0]  id,
                                     input logic [CmdW-1:0] fn,
                                     input logic [ValW-1:0] v);
    pkt_t                       p;
    logic [1:0]                 gm1;
    logic [ByteW-1:0]           sum;
    logic [NGrp-1:0][GrpW-1:0]  grp;
    grp[3] = v[27:21];
    grp[2] = v[20:14];
    grp[1] = v[13:7];
    grp[0] = v[6:0];
    // fewest 7-bit groups whose signed range holds the value
    if ((&v[27:6]) || !(|v[27:6])) begin
      gm1 = 2'd0;
    end else if ((&v[27:13]) || !(|v[27:13])) begin
      gm1 = 2'd1;
    end else if ((&v[27:20]) || !(|v[27:20])) begin
      gm1 = 2'd2;
    end else begin
      gm1 = 2'd3;
    end
    p.bytes    = '0;
    p.bytes[0] = {1'b0, id};
    p.bytes[1] = {1'b1, gm1, fn};
    sum        = p.bytes[0] + p.bytes[1];
    for (int k = 0; k < NGrp; k++) begin
      if (2'(k) <= gm1 && k < NGrp) begin
        p.bytes[IdxW'(k) + IdxW'(2)] = MarkBit | {1'b0, grp[2'(gm1 - 2'(k))]};
        sum = sum + p.bytes[IdxW'(k) + IdxW'(2)];
      end
    end
    p.last_idx          = IdxW'(3) + {1'b0, gm1};
    p.bytes[p.last_idx] = sum | MarkBit;
    return p;
  endfunction

endpackage

`default_nettype wire

### sv/spe_ifs.sv
// stream interfaces: command beats in, packet byte beats out
`default_nettype none

interface spe_cmd_if;
  logic               valid;
  logic               ready;
  logic [6:0]         drive_id;
  logic [4:0]         cmd;
  logic signed [27:0] value;

  modport source (output valid, drive_id, cmd, value, input ready);
  modport sink   (input valid, drive_id, cmd, value, output ready);
endinterface

interface spe_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, out_byte, last, input ready);
  modport sink   (input valid, out_byte, last, output ready);
endinterface

`default_nettype wire

### sv/spe_build.sv
// command input register and packet image builder
`default_nettype none

module spe_build import spe_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  spe_cmd_if.sink   in_cmd,
  output pkt_t      pkt,
  output logic      pkt_valid,
  input  logic      pkt_take
);

  logic             valid_r;
  logic [IdW-1:0]   id_r;
  logic [CmdW-1:0]  cmd_r;
  logic [ValW-1:0]  value_r;
  logic             accept;

  assign in_cmd.ready = rst_n && (!valid_r || pkt_take);
  assign accept       = in_cmd.valid && in_cmd.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (accept) begin
      valid_r <= 1'b1;
    end else if (pkt_take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      id_r    <= in_cmd.drive_id;
      cmd_r   <= in_cmd.cmd;
      value_r <= ValW'(in_cmd.value);
    end
  end

  assign pkt       = build_pkt(id_r, cmd_r, value_r);
  assign pkt_valid = valid_r;

endmodule

`default_nettype wire

### sv/spe_ser.sv
// packet buffer that sends one byte beat per cycle while out_pkt.ready is high
`default_nettype none

module spe_ser import spe_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  pkt_t       pkt,
  input  logic       pkt_valid,
  output logic       pkt_take,
  spe_byte_if.source out_pkt
);

  pkt_t             buf_r;
  logic             busy_r;
  logic [IdxW-1:0]  idx_r;
  logic             at_last;
  logic             done;

  assign at_last  = (idx_r == buf_r.last_idx);
  assign done     = busy_r && out_pkt.ready && at_last;
  // next packet loads as the checksum beat leaves, so packets run without gaps
  assign pkt_take = pkt_valid && (!busy_r || done);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (pkt_take) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (done) begin
      busy_r <= 1'b0;
    end else if (busy_r && out_pkt.ready) begin
      idx_r <= idx_r + IdxW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (pkt_take) begin
      buf_r <= pkt;
    end
  end

  assign out_pkt.valid    = busy_r;
  assign out_pkt.out_byte = buf_r.bytes[idx_r];
  assign out_pkt.last     = at_last;

endmodule

`default_nettype wire

### sv/servo_packet_encoder_top.sv
// Servo packet encoder: each command beat (drive id, function code, signed
// 28-bit value) becomes a packet of 4 to 7 bytes: start byte, length/function
// byte, 1 to 4 data groups and a checksum byte flagged by last. Bytes leave
// one per cycle from the byte serializer while the output is ready. A command
// is held in the input register while the previous packet is sent, and its
// first byte follows the previous checksum byte in the next cycle; with the
// serializer idle the command passes through the input register and then the
// packet buffer before its first byte is valid.
`default_nettype none

module servo_packet_encoder_top import spe_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  spe_cmd_if.sink    in_cmd,
  spe_byte_if.source out_pkt
);

  pkt_t pkt;
  logic pkt_valid;
  logic pkt_take;

  spe_build u_build (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_cmd    (in_cmd),
    .pkt       (pkt),
    .pkt_valid (pkt_valid),
    .pkt_take  (pkt_take)
  );

  spe_ser u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .pkt       (pkt),
    .pkt_valid (pkt_valid),
    .pkt_take  (pkt_take),
    .out_pkt   (out_pkt)
  );

endmodule

`default_nettype wire

### sv/spe_chk.sv
// port checker for the servo packet encoder and its bind
`default_nettype none

module spe_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last
);

  logic       beat;
  logic [2:0] pos_r;

  assign beat = out_valid && out_ready;

  // byte position within the current packet
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (beat) begin
      pos_r <= out_last ? 3'd0 : pos_r + 3'd1;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output beat withdrawn while stalled");

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    beat && pos_r == 3'd0 |-> !out_byte[7])
    else $error("start byte has bit 7 set");

  a_body: assert property (@(posedge clk) disable iff (!rst_n)
    beat && pos_r != 3'd0 |-> out_byte[7])
    else $error("non-start byte has bit 7 clear");

  a_short: assert property (@(posedge clk) disable iff (!rst_n)
    beat && out_last |-> pos_r >= 3'd3)
    else $error("packet shorter than four bytes");

  a_long: assert property (@(posedge clk) disable iff (!rst_n)
    beat && pos_r == 3'd6 |-> out_last)
    else $error("packet longer than seven bytes");

endmodule

bind servo_packet_encoder_top spe_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_pkt.valid),
  .out_ready (out_pkt.ready),
  .out_byte  (out_pkt.out_byte),
  .out_last  (out_pkt.last)
);

`default_nettype wire
